>>> rtl/core/crm3_pkg.sv
`timescale 1ns / 1ps
package crm3_pkg;
	// Word format of every coefficient, constant and solution
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Internal widths of the determinant datapath
	localparam int PROD_W = 2 * WORD_BITS;          // 2x2 product
	localparam int MIN_W  = PROD_W + 1;             // minor (difference of products)
	localparam int PP_W   = 2 * WORD_BITS + 1;      // minor half times coefficient
	localparam int DET_W  = 3 * WORD_BITS + 3;      // full 3x3 determinant
	localparam int NUM_W  = DET_W + FRAC_BITS;      // scaled dividend magnitude
	localparam int CMP_W  = NUM_W + WORD_BITS + 1;  // divider compare width

	// Pipeline depth: six determinant stages, WORD_BITS+1 divider stages, output
	localparam int NST = 6 + WORD_BITS + 1 + 1;

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam logic [WORD_BITS-1:0] SOL_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] SOL_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
endpackage

>>> rtl/core/cramer_3x3_solver.sv
`timescale 1ns / 1ps
// Throughput: one system per cycle unless a held result is stalled at the output; the
// six determinant stages and the WORD_BITS+1 stage restoring divider (an entry stage,
// then one quotient bit per stage) are all pipelined.
// A stall of a held result freezes the whole pipeline; nothing is lost or repeated.
// Reset: arst_n clears all stage valid bits asynchronously; data registers are not reset.
module cramer_3x3_solver (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  crm3_pkg::word_t coef_r0_x,
	input  crm3_pkg::word_t coef_r0_y,
	input  crm3_pkg::word_t coef_r0_z,
	input  crm3_pkg::word_t coef_r1_x,
	input  crm3_pkg::word_t coef_r1_y,
	input  crm3_pkg::word_t coef_r1_z,
	input  crm3_pkg::word_t coef_r2_x,
	input  crm3_pkg::word_t coef_r2_y,
	input  crm3_pkg::word_t coef_r2_z,
	input  crm3_pkg::word_t rhs_first,
	input  crm3_pkg::word_t rhs_second,
	input  crm3_pkg::word_t rhs_third,
	output logic            out_valid,
	input  logic            out_stall,
	output crm3_pkg::word_t sol_x,
	output crm3_pkg::word_t sol_y,
	output crm3_pkg::word_t sol_z,
	output logic            singular,
	output logic            saturated
);
	import crm3_pkg::*;

	logic adv;
	logic [NST-1:0] pv_q;

	word_t coef_c [3][3];
	word_t rhs_c  [3];
	word_t mat_c  [4][3][3];

	logic signed [PROD_W-1:0] prod_s1 [4][6];
	word_t                    row0_s1 [4][3];
	logic signed [MIN_W-1:0]  minor_s2 [4][3];
	word_t                    row0_s2 [4][3];
	logic signed [PP_W-1:0]   plo_s3 [4][3];
	logic signed [PP_W-1:0]   phi_s3 [4][3];
	logic signed [DET_W-1:0]  term_s4 [4][3];
	logic signed [DET_W-1:0]  det_s5 [4];
	logic [DET_W-1:0]         nmag_s6 [3];
	logic [DET_W-1:0]         dmag_s6;
	logic [2:0]               neg_s6;
	logic                     sing_s6;

	// Divider pipeline, one entry per divider stage
	logic [NUM_W-1:0]     rem_s7  [0:WORD_BITS][3];
	logic [DET_W-1:0]     dm_s7   [0:WORD_BITS][3];
	logic [WORD_BITS-1:0] quo_s7  [0:WORD_BITS][3];
	logic [2:0]           ovf_s7  [0:WORD_BITS];
	logic [2:0]           neg_s7  [0:WORD_BITS];
	logic                 sing_s7 [0:WORD_BITS];

	logic                 ge_c  [1:WORD_BITS][3];
	logic [NUM_W-1:0]     sub_c [1:WORD_BITS][3];

	logic [WORD_BITS-1:0] sol_q [3];
	logic                 sing_q;
	logic                 sat_q;

	// Advance the whole pipeline unless a finished result is held
	assign adv       = !(pv_q[NST-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = pv_q[NST-1];

	// Build the system matrix and the three column-replaced matrices
	always_comb begin
		coef_c[0][0] = coef_r0_x; coef_c[0][1] = coef_r0_y; coef_c[0][2] = coef_r0_z;
		coef_c[1][0] = coef_r1_x; coef_c[1][1] = coef_r1_y; coef_c[1][2] = coef_r1_z;
		coef_c[2][0] = coef_r2_x; coef_c[2][1] = coef_r2_y; coef_c[2][2] = coef_r2_z;
		rhs_c[0] = rhs_first;
		rhs_c[1] = rhs_second;
		rhs_c[2] = rhs_third;
		for (int k = 0; k < 4; k++)
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					mat_c[k][i][j] = (k != 0 && j == k - 1) ? rhs_c[i] : coef_c[i][j];
	end

	// Divider compare-subtract for each quotient bit
	always_comb begin
		for (int j = 1; j <= WORD_BITS; j++)
			for (int l = 0; l < 3; l++) begin
				ge_c[j][l]  = CMP_W'(rem_s7[j-1][l]) >= (CMP_W'(dm_s7[j-1][l]) << (WORD_BITS - j));
				sub_c[j][l] = NUM_W'(CMP_W'(rem_s7[j-1][l])
					- (CMP_W'(dm_s7[j-1][l]) << (WORD_BITS - j)));
			end
	end

	// Shift stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else if (adv) begin
			pv_q <= {pv_q[NST-2:0], in_valid};
		end
	end

	// Determinant, divider and output stages
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				prod_s1[k][0] <= mat_c[k][1][1] * mat_c[k][2][2];
				prod_s1[k][1] <= mat_c[k][1][2] * mat_c[k][2][1];
				prod_s1[k][2] <= mat_c[k][1][0] * mat_c[k][2][2];
				prod_s1[k][3] <= mat_c[k][1][2] * mat_c[k][2][0];
				prod_s1[k][4] <= mat_c[k][1][0] * mat_c[k][2][1];
				prod_s1[k][5] <= mat_c[k][1][1] * mat_c[k][2][0];
				for (int j = 0; j < 3; j++) begin
					row0_s1[k][j] <= mat_c[k][0][j];
					minor_s2[k][j] <= MIN_W'(prod_s1[k][2*j]) - MIN_W'(prod_s1[k][2*j+1]);
					row0_s2[k][j] <= row0_s1[k][j];
					plo_s3[k][j] <= $signed({1'b0, minor_s2[k][j][WORD_BITS-1:0]})
						* row0_s2[k][j];
					phi_s3[k][j] <= $signed(minor_s2[k][j][MIN_W-1:WORD_BITS]) * row0_s2[k][j];
					term_s4[k][j] <= (DET_W'(phi_s3[k][j]) <<< WORD_BITS) + DET_W'(plo_s3[k][j]);
				end
				det_s5[k] <= term_s4[k][0] - term_s4[k][1] + term_s4[k][2];
			end

			// Take magnitudes and signs for the three quotients
			sing_s6 <= (det_s5[0] == '0);
			dmag_s6 <= det_s5[0][DET_W-1] ? DET_W'(-det_s5[0]) : DET_W'(det_s5[0]);
			for (int l = 0; l < 3; l++) begin
				nmag_s6[l] <= det_s5[l+1][DET_W-1] ? DET_W'(-det_s5[l+1]) : DET_W'(det_s5[l+1]);
				neg_s6[l]  <= (det_s5[l+1][DET_W-1] ^ det_s5[0][DET_W-1]) && (det_s5[l+1] != '0);
			end

			// Divider entry: scale dividend, detect a quotient of 2^WORD_BITS or more
			for (int l = 0; l < 3; l++) begin
				rem_s7[0][l]    <= NUM_W'(nmag_s6[l]) << FRAC_BITS;
				dm_s7[0][l]     <= dmag_s6;
				quo_s7[0][l]    <= '0;
				ovf_s7[0][l]    <= (CMP_W'(NUM_W'(nmag_s6[l]) << FRAC_BITS))
					>= (CMP_W'(dmag_s6) << WORD_BITS);
			end
			neg_s7[0]  <= neg_s6;
			sing_s7[0] <= sing_s6;

			// One quotient bit per divider stage
			for (int j = 1; j <= WORD_BITS; j++) begin
				for (int l = 0; l < 3; l++) begin
					rem_s7[j][l] <= ge_c[j][l] ? sub_c[j][l] : rem_s7[j-1][l];
					dm_s7[j][l]  <= dm_s7[j-1][l];
					quo_s7[j][l] <= {quo_s7[j-1][l][WORD_BITS-2:0], ge_c[j][l]};
				end
				ovf_s7[j]  <= ovf_s7[j-1];
				neg_s7[j]  <= neg_s7[j-1];
				sing_s7[j] <= sing_s7[j-1];
			end

			// Sign, saturate and zero the singular case
			sing_q <= sing_s7[WORD_BITS];
			for (int l = 0; l < 3; l++) begin
				if (sing_s7[WORD_BITS]) begin
					sol_q[l] <= '0;
				end else if (ovf_s7[WORD_BITS][l]
					|| (neg_s7[WORD_BITS][l] && quo_s7[WORD_BITS][l] > SOL_MIN)
					|| (!neg_s7[WORD_BITS][l] && quo_s7[WORD_BITS][l] > SOL_MAX)) begin
					sol_q[l] <= neg_s7[WORD_BITS][l] ? SOL_MIN : SOL_MAX;
				end else begin
					sol_q[l] <= neg_s7[WORD_BITS][l] ? -quo_s7[WORD_BITS][l]
						: quo_s7[WORD_BITS][l];
				end
			end
			sat_q <= !sing_s7[WORD_BITS] && (ovf_s7[WORD_BITS] != 3'b000
				|| (neg_s7[WORD_BITS][0] && quo_s7[WORD_BITS][0] > SOL_MIN)
				|| (!neg_s7[WORD_BITS][0] && quo_s7[WORD_BITS][0] > SOL_MAX)
				|| (neg_s7[WORD_BITS][1] && quo_s7[WORD_BITS][1] > SOL_MIN)
				|| (!neg_s7[WORD_BITS][1] && quo_s7[WORD_BITS][1] > SOL_MAX)
				|| (neg_s7[WORD_BITS][2] && quo_s7[WORD_BITS][2] > SOL_MIN)
				|| (!neg_s7[WORD_BITS][2] && quo_s7[WORD_BITS][2] > SOL_MAX));
		end
	end

	assign sol_x     = word_t'(sol_q[0]);
	assign sol_y     = word_t'(sol_q[1]);
	assign sol_z     = word_t'(sol_q[2]);
	assign singular  = sing_q;
	assign saturated = sat_q;

`ifndef SYNTHESIS
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> sol_x == '0 && sol_y == '0 && sol_z == '0 && !saturated)
		else $error("singular result carries nonzero solution");
	a_stall_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (pv_q[NST-1] && out_stall))
		else $error("input stall does not follow held output");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pv_q[0])
		else $error("transfer did not enter first stage");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(pv_q))
		else $error("pipeline moved while stalled");
`endif
endmodule
